// File: design/rpp_pkg.sv
// ----------------------------------------------------------------------------
// rpp_pkg: shared types and codes for the reference-counted packet pool
// Request, result and configuration payloads, the classified command that
// passes from the front end to the back end, and the back-end sequencer states.
// ----------------------------------------------------------------------------
package rpp_pkg;

  // Request type codes as they arrive on the request channel
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_SUBMIT  = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  // Configuration register indexes
  localparam logic CFG_POOL_PACKETS = 1'b0;
  localparam logic CFG_PACKET_BYTES = 1'b1;

  // Fixed field widths and queue depth
  localparam int RC_W        = 4;
  localparam int OFFSET_W    = 20;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [1:0]          src_t;
  typedef logic [3:0]          pkt_idx_t;
  typedef logic [3:0]          fan_t;
  typedef logic [4:0]          cnt_out_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [15:0]         bytes_t;
  typedef logic [RC_W-1:0]     ref_cnt_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  // Operation after classification
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_SUBMIT,
    OP_RELEASE,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STACK,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    logic [1:0] req_type;
    src_t       source;
    pkt_idx_t   packet_index;
    fan_t       fanout;
  } req_t;

  typedef struct packed {
    status_e  status;
    pkt_idx_t granted_index;
    offset_t  byte_offset;
    logic     freed;
    cnt_out_t free_count;
  } res_t;

  typedef struct packed {
    logic   index;
    bytes_t value;
  } cfg_t;

  // Classified request held in the queue between front and back
  typedef struct packed {
    op_e      op;
    src_t     src;
    pkt_idx_t pkt;
    fan_t     fan;
    logic     src_ok;
    logic     idx_ok;
  } cmd_t;

endpackage

// File: design/rpp_stream_if.sv
// ----------------------------------------------------------------------------
// rpp_stream_if: valid/ready channel carrying one payload per request
// The source drives valid and data, the sink drives ready.
// ----------------------------------------------------------------------------
interface rpp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/refcounted_packet_pool.sv
// ----------------------------------------------------------------------------
// refcounted_packet_pool: per-source multicast packet buffer manager
// Allocates packet indices from per-source LIFO free lists and tracks their
// reference counts through submit and release.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  - request channel (req_type, source, packet_index, fanout).
//   res_o  - one result per request (status, granted_index, byte_offset,
//            freed, free_count), in request order.
//   cfg_i  - register writes: index 0 pool_packets, index 1 packet_bytes.
//            Write only while no request is in flight; a pool_packets write
//            refills every free list and clears all reference counts.
// Timing:
//   A request is queued on acceptance. The back end takes it, reads the
//   stack top and packet state memories, then writes them back; allocate
//   also reads the free stack before it writes, at an address given by the
//   stack top it has just read.
// Reset:
//   Free lists are full (index 0 on top), pool_packets 16, packet_bytes 64.
//   Entry valid bits give the reset contents at once; there is no clearing
//   pass. When the receiver stalls the result is held and up to three further
//   requests are taken (one waiting in the back end, two in the queue) before
//   req_i.ready drops.
// ----------------------------------------------------------------------------
module refcounted_packet_pool #(
  parameter int SOURCES    = 4,
  parameter int PACKETS    = 16,
  parameter int MAX_FANOUT = 15
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpp_stream_if.sink   req_i,
  rpp_stream_if.sink   cfg_i,
  rpp_stream_if.source res_o
);

  localparam int CNT_W = $clog2(PACKETS + 1);

  logic                  push_valid, push_ready;
  rpp_pkg::cmd_t         push_data;
  logic                  pop_valid, pop_ready;
  rpp_pkg::cmd_t         pop_data;
  logic [CNT_W-1:0]      pool;

  // Classify incoming requests
  rpp_front #(
    .SOURCES    (SOURCES),
    .PACKETS    (PACKETS),
    .MAX_FANOUT (MAX_FANOUT)
  ) u_front (
    .req_i        (req_i),
    .pool_i       (pool),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple front and back
  rpp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Execute against the pool state
  rpp_back #(
    .SOURCES (SOURCES),
    .PACKETS (PACKETS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .pool_o      (pool),
    .res_o       (res_o)
  );

endmodule

// File: design/rpp_ram.sv
// ----------------------------------------------------------------------------
// rpp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rpp_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/rpp_front.sv
// ----------------------------------------------------------------------------
// rpp_front: request front end
// Accepts requests, checks source and index range, clamps the fanout and
// hands a classified command to the queue.
// ----------------------------------------------------------------------------
module rpp_front #(
  parameter int SOURCES    = 4,
  parameter int PACKETS    = 16,
  parameter int MAX_FANOUT = 15
) (
  rpp_stream_if.sink                  req_i,
  input  logic [$clog2(PACKETS+1)-1:0] pool_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output rpp_pkg::cmd_t               push_data_o
);

  logic src_ok;

  // Pass the handshake straight on to the queue
  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

  // Classify the request
  always_comb begin
    src_ok = 32'(req_i.data.source) < SOURCES;

    push_data_o        = '0;
    push_data_o.src_ok = src_ok;
    push_data_o.src    = src_ok ? req_i.data.source : '0;
    push_data_o.pkt    = req_i.data.packet_index;
    push_data_o.idx_ok = 32'(req_i.data.packet_index) < 32'(pool_i);
    push_data_o.fan    = (32'(req_i.data.fanout) > MAX_FANOUT) ?
                         rpp_pkg::fan_t'(MAX_FANOUT) : req_i.data.fanout;

    case (req_i.data.req_type)
      rpp_pkg::REQ_ALLOC:   push_data_o.op = rpp_pkg::OP_ALLOC;
      rpp_pkg::REQ_SUBMIT:  push_data_o.op = rpp_pkg::OP_SUBMIT;
      rpp_pkg::REQ_RELEASE: push_data_o.op = rpp_pkg::OP_RELEASE;
      default:              push_data_o.op = rpp_pkg::OP_BAD;
    endcase

    // Mark any request to a source that does not exist as bad
    if (!src_ok) begin
      push_data_o.op = rpp_pkg::OP_BAD;
    end
  end

endmodule

// File: design/rpp_queue.sv
// ----------------------------------------------------------------------------
// rpp_queue: short command queue between front and back end
// A small FIFO of classified commands so that either side can stall.
// ----------------------------------------------------------------------------
module rpp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rpp_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rpp_pkg::cmd_t pop_data_o
);

  localparam int PTR_W = (rpp_pkg::QUEUE_DEPTH > 1) ? $clog2(rpp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(rpp_pkg::QUEUE_DEPTH + 1);

  rpp_pkg::cmd_t    slot_q [rpp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = 32'(count_q) < rpp_pkg::QUEUE_DEPTH;
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == rpp_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == rpp_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/rpp_back.sv
// ----------------------------------------------------------------------------
// rpp_back: request back end
// Holds the configuration, the per-source free stacks, stack tops and packet
// state, runs each command as a read then a write and drives the result.
// ----------------------------------------------------------------------------
module rpp_back #(
  parameter int SOURCES = 4,
  parameter int PACKETS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rpp_stream_if.sink                   cfg_i,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  rpp_pkg::cmd_t                pop_data_i,
  output logic [$clog2(PACKETS+1)-1:0] pool_o,
  rpp_stream_if.source                 res_o
);

  localparam int CNT_W     = $clog2(PACKETS + 1);
  localparam int IDX_W     = (PACKETS > 1) ? $clog2(PACKETS) : 1;
  localparam int SRC_W     = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int STK_DEPTH = SOURCES * PACKETS;
  localparam int AW        = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
  localparam int PKT_W     = rpp_pkg::RC_W + 1;
  localparam int POOL_RST  = (PACKETS < 16) ? PACKETS : 16;

  function automatic logic [AW-1:0] slot_addr(input logic [SRC_W-1:0] s,
                                              input logic [IDX_W-1:0] k);
    slot_addr = AW'(32'(s) * PACKETS + 32'(k));
  endfunction

  // Configuration
  logic [CNT_W-1:0]     pool_q, pool_wr;
  rpp_pkg::bytes_t      bytes_q;
  logic                 pool_we, bytes_we;

  // Sequencer
  rpp_pkg::bk_state_e   state_q, state_d;
  rpp_pkg::cmd_t        cmd_q;
  logic                 pop, exec_go, out_free;

  // Memory ports
  logic                 top_re, top_we;
  logic [SRC_W-1:0]     top_raddr, top_waddr;
  logic [CNT_W-1:0]     top_rd, top_wdata;
  logic                 stk_re, stk_we;
  logic [AW-1:0]        stk_raddr, stk_waddr;
  logic [IDX_W-1:0]     stk_rd, stk_wdata;
  logic                 pkt_re, pkt_we;
  logic [AW-1:0]        pkt_raddr, pkt_waddr;
  logic [PKT_W-1:0]     pkt_rd, pkt_wdata;

  // Entry valid bits and their registered reads
  logic                 top_vld_q [SOURCES];
  logic                 stk_vld_q [STK_DEPTH];
  logic                 pkt_vld_q [STK_DEPTH];
  logic                 top_rd_vld_q, stk_rd_vld_q, pkt_rd_vld_q;

  // Execution
  logic [SRC_W-1:0]     src;
  logic [IDX_W-1:0]     idx, alloc_idx, off_idx;
  logic [CNT_W-1:0]     top_cur, top_new;
  logic                 in_use, off_en;
  rpp_pkg::ref_cnt_t    rc, rc_new;
  logic                 push_en;
  logic                 top_we_x, stk_we_x, pkt_we_x;
  rpp_pkg::res_t        res_d, res_q;
  logic                 out_valid_q;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;
  assign pool_we     = cfg_i.valid && (cfg_i.data.index == rpp_pkg::CFG_POOL_PACKETS);
  assign bytes_we    = cfg_i.valid && (cfg_i.data.index == rpp_pkg::CFG_PACKET_BYTES);
  assign pool_o      = pool_q;

  // Clamp the pool size to one up to the packet count
  always_comb begin
    if (cfg_i.data.value[4:0] == 5'd0) begin
      pool_wr = CNT_W'(1);
    end else if (32'(cfg_i.data.value[4:0]) > PACKETS) begin
      pool_wr = CNT_W'(PACKETS);
    end else begin
      pool_wr = CNT_W'(cfg_i.data.value[4:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= CNT_W'(POOL_RST);
      bytes_q <= 16'd64;
    end else begin
      if (pool_we) begin
        pool_q <= pool_wr;
      end
      if (bytes_we) begin
        bytes_q <= cfg_i.data.value;
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  assign out_free = !out_valid_q || res_o.ready;
  assign pop      = pop_valid_i && pop_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpp_pkg::BK_IDLE: begin
        if (pop_valid_i) begin
          state_d = (pop_data_i.op == rpp_pkg::OP_ALLOC) ? rpp_pkg::BK_STACK
                                                          : rpp_pkg::BK_EXEC;
        end
      end
      rpp_pkg::BK_STACK: state_d = rpp_pkg::BK_EXEC;
      rpp_pkg::BK_EXEC: begin
        if (out_free) begin
          state_d = rpp_pkg::BK_IDLE;
        end
      end
      default: state_d = rpp_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs: pop and read issue
  always_comb begin
    pop_ready_o = 1'b0;
    exec_go     = 1'b0;
    stk_re      = 1'b0;
    case (state_q)
      rpp_pkg::BK_IDLE:  pop_ready_o = 1'b1;
      rpp_pkg::BK_STACK: stk_re      = top_cur != '0;
      rpp_pkg::BK_EXEC:  exec_go     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpp_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= pop_data_i;
    end
  end

  // Read addresses: stack top and packet state from the queue head, free stack from the held command
  assign top_re    = pop;
  assign pkt_re    = pop;
  assign top_raddr = SRC_W'(pop_data_i.src);
  assign pkt_raddr = slot_addr(SRC_W'(pop_data_i.src),
                               pop_data_i.idx_ok ? IDX_W'(pop_data_i.pkt) : '0);
  assign stk_raddr = slot_addr(src, IDX_W'(top_cur - CNT_W'(1)));

  // ---------------------------------------------------------------- memories
  rpp_ram #(.WIDTH(CNT_W), .DEPTH(SOURCES)) u_top_ram (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (top_waddr),
    .wdata_i (top_wdata),
    .re_i    (top_re),
    .raddr_i (top_raddr),
    .rdata_o (top_rd)
  );

  rpp_ram #(.WIDTH(IDX_W), .DEPTH(STK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rd)
  );

  rpp_ram #(.WIDTH(PKT_W), .DEPTH(STK_DEPTH)) u_pkt_ram (
    .clk_i   (clk_i),
    .we_i    (pkt_we),
    .waddr_i (pkt_waddr),
    .wdata_i (pkt_wdata),
    .re_i    (pkt_re),
    .raddr_i (pkt_raddr),
    .rdata_o (pkt_rd)
  );

  // Valid bits: cleared at reset and on a pool size write, set on write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SOURCES; i++) top_vld_q[i] <= 1'b0;
      for (int i = 0; i < STK_DEPTH; i++) begin
        stk_vld_q[i] <= 1'b0;
        pkt_vld_q[i] <= 1'b0;
      end
    end else if (pool_we) begin
      for (int i = 0; i < SOURCES; i++) top_vld_q[i] <= 1'b0;
      for (int i = 0; i < STK_DEPTH; i++) begin
        stk_vld_q[i] <= 1'b0;
        pkt_vld_q[i] <= 1'b0;
      end
    end else begin
      if (top_we) top_vld_q[top_waddr] <= 1'b1;
      if (stk_we) stk_vld_q[stk_waddr] <= 1'b1;
      if (pkt_we) pkt_vld_q[pkt_waddr] <= 1'b1;
    end
  end

  // Read valid bits alongside the RAM data
  always_ff @(posedge clk_i) begin
    if (top_re) top_rd_vld_q <= top_vld_q[top_raddr];
    if (stk_re) stk_rd_vld_q <= stk_vld_q[stk_raddr];
    if (pkt_re) pkt_rd_vld_q <= pkt_vld_q[pkt_raddr];
  end

  // ---------------------------------------------------------------- execute
  assign src       = SRC_W'(cmd_q.src);
  assign idx       = cmd_q.idx_ok ? IDX_W'(cmd_q.pkt) : '0;
  assign top_cur   = top_rd_vld_q ? top_rd : pool_q;
  assign in_use    = pkt_rd_vld_q && pkt_rd[rpp_pkg::RC_W];
  assign rc        = pkt_rd_vld_q ? pkt_rd[rpp_pkg::RC_W-1:0] : '0;
  // Unwritten stack slot k holds pool-1-k
  assign alloc_idx = stk_rd_vld_q ? stk_rd
                                  : IDX_W'(pool_q - CNT_W'(1) - (top_cur - CNT_W'(1)));

  always_comb begin
    res_d               = '0;
    res_d.status        = rpp_pkg::ST_BAD;
    res_d.granted_index = cmd_q.pkt;
    top_new             = top_cur;
    off_en              = 1'b0;
    off_idx             = idx;
    push_en             = 1'b0;
    rc_new              = rc;
    top_we_x            = 1'b0;
    pkt_we_x            = 1'b0;
    pkt_waddr           = slot_addr(src, idx);
    pkt_wdata           = '0;

    case (cmd_q.op)
      rpp_pkg::OP_ALLOC: begin
        res_d.granted_index = '0;
        if (top_cur == '0) begin
          res_d.status = rpp_pkg::ST_EMPTY;
        end else begin
          res_d.status        = rpp_pkg::ST_OK;
          res_d.granted_index = rpp_pkg::pkt_idx_t'(alloc_idx);
          off_en              = 1'b1;
          off_idx             = alloc_idx;
          top_new             = top_cur - CNT_W'(1);
          top_we_x            = 1'b1;
          pkt_we_x            = 1'b1;
          pkt_waddr           = slot_addr(src, alloc_idx);
          pkt_wdata           = {1'b1, rpp_pkg::ref_cnt_t'(0)};
        end
      end
      rpp_pkg::OP_SUBMIT: begin
        if (cmd_q.idx_ok && in_use && rc == '0) begin
          res_d.status = rpp_pkg::ST_OK;
          off_en       = 1'b1;
          rc_new       = rpp_pkg::ref_cnt_t'(cmd_q.fan);
          pkt_we_x     = 1'b1;
          pkt_wdata    = {rc_new != '0, rc_new};
          push_en      = rc_new == '0;
        end
      end
      rpp_pkg::OP_RELEASE: begin
        if (cmd_q.idx_ok && in_use && rc != '0) begin
          res_d.status = rpp_pkg::ST_OK;
          off_en       = 1'b1;
          rc_new       = rc - 1'b1;
          pkt_we_x     = 1'b1;
          pkt_wdata    = {rc_new != '0, rc_new};
          push_en      = rc_new == '0;
        end
      end
      default: ;
    endcase

    // Push the freed index back onto the stack
    res_d.freed = push_en;
    stk_we_x    = 1'b0;
    if (push_en && (32'(top_cur) < PACKETS)) begin
      stk_we_x = 1'b1;
      top_we_x = 1'b1;
      top_new  = top_cur + CNT_W'(1);
    end

    res_d.byte_offset = off_en ? rpp_pkg::OFFSET_W'(32'(off_idx) * 32'(bytes_q)) : '0;
    res_d.free_count  = cmd_q.src_ok ? rpp_pkg::cnt_out_t'(top_new) : '0;
  end

  // Commit writes only when the result can be taken
  assign top_we    = exec_go && top_we_x;
  assign top_waddr = src;
  assign top_wdata = top_new;
  assign stk_we    = exec_go && stk_we_x;
  assign stk_waddr = slot_addr(src, IDX_W'(top_cur));
  assign stk_wdata = idx;
  assign pkt_we    = exec_go && pkt_we_x;

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

`ifndef SYNTHESIS
  a_freed_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.freed |-> res_o.data.status == rpp_pkg::ST_OK)
    else $error("freed result without ok status");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.status == rpp_pkg::ST_EMPTY |->
      res_o.data.free_count == '0 && res_o.data.granted_index == '0)
    else $error("empty pool result with nonzero count or index");

  a_exec_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> res_o.valid)
    else $error("executed request produced no result");

  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> state_q != rpp_pkg::BK_IDLE)
    else $error("sequencer stayed idle after taking a command");
`endif

endmodule

// File: verif/refcounted_packet_pool_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_packet_pool_tb: self-checking bench for the packet pool
// Drives allocate, submit and release requests over several pool and packet
// size settings, predicts every result in a scoreboard and compares it field
// by field with what the pool returns, under random idling on both channels.
// ----------------------------------------------------------------------------
module refcounted_packet_pool_tb;

  localparam int          SOURCES     = 4;
  localparam int          PACKETS     = 16;
  localparam int          MAX_FANOUT  = 15;
  localparam logic [1:0]  REQ_UNKNOWN = 2'd3;
  localparam int          NUM_PHASES  = 8;
  localparam int          PHASE_ITEMS = 228;
  localparam int          HOLD_OFF    = 4;
  localparam int          STALL_LIMIT = 500;

  // Reference state of every source pool and the queue of pending results
  class pool_scoreboard;
    rpp_pkg::pkt_idx_t free_stack[SOURCES][PACKETS];
    int unsigned       free_top[SOURCES];
    bit                in_use[SOURCES][PACKETS];
    rpp_pkg::ref_cnt_t ref_cnt[SOURCES][PACKETS];
    int unsigned       pool_size;
    rpp_pkg::bytes_t   pkt_bytes;
    rpp_pkg::res_t     pending_results[$];
    int unsigned       failures;

    function new();
      pkt_bytes = 16'd64;
      failures  = 0;
      resize_pools(PACKETS);
    endfunction

    // Refill every free list, index 0 on top, and clear all packet state
    function void resize_pools(int unsigned v);
      pool_size = (v < 1) ? 1 : (v > PACKETS) ? PACKETS : v;
      for (int s = 0; s < SOURCES; s++) begin
        for (int k = 0; k < PACKETS; k++) begin
          free_stack[s][k] = rpp_pkg::pkt_idx_t'(pool_size - 1 - k);
          in_use[s][k]     = 1'b0;
          ref_cnt[s][k]    = '0;
        end
        free_top[s] = pool_size;
      end
    endfunction

    function void write_register(rpp_pkg::cfg_t c);
      if (c.index == rpp_pkg::CFG_POOL_PACKETS) begin
        resize_pools(c.value[4:0]);
      end else begin
        pkt_bytes = c.value;
      end
    endfunction

    function rpp_pkg::offset_t offset_of(rpp_pkg::pkt_idx_t idx);
      logic [31:0] prod;
      prod = idx * pkt_bytes;
      return prod[rpp_pkg::OFFSET_W-1:0];
    endfunction

    function void push_free(int unsigned s, rpp_pkg::pkt_idx_t idx);
      if (free_top[s] < PACKETS) begin
        free_stack[s][free_top[s]] = idx;
        free_top[s]++;
      end
      in_use[s][idx] = 1'b0;
    endfunction

    // Apply one accepted request and queue the result it must produce
    function void note_request(rpp_pkg::req_t r);
      rpp_pkg::res_t     e;
      int unsigned       s;
      rpp_pkg::pkt_idx_t idx;
      rpp_pkg::pkt_idx_t g;
      bit                idx_ok;
      s      = r.source;
      idx    = r.packet_index;
      idx_ok = idx < pool_size;
      e.status        = rpp_pkg::ST_BAD;
      e.granted_index = idx;
      e.byte_offset   = '0;
      e.freed         = 1'b0;
      case (r.req_type)
        rpp_pkg::REQ_ALLOC: begin
          e.granted_index = '0;
          if (free_top[s] == 0) begin
            e.status = rpp_pkg::ST_EMPTY;
          end else begin
            free_top[s]--;
            g = free_stack[s][free_top[s]];
            in_use[s][g]    = 1'b1;
            ref_cnt[s][g]   = '0;
            e.granted_index = g;
            e.byte_offset   = offset_of(g);
            e.status        = rpp_pkg::ST_OK;
          end
        end
        rpp_pkg::REQ_SUBMIT: begin
          if (idx_ok && in_use[s][idx] && ref_cnt[s][idx] == 0) begin
            ref_cnt[s][idx] = r.fanout;
            if (r.fanout == 0) begin
              push_free(s, idx);
              e.freed = 1'b1;
            end
            e.byte_offset = offset_of(idx);
            e.status      = rpp_pkg::ST_OK;
          end
        end
        rpp_pkg::REQ_RELEASE: begin
          if (idx_ok && in_use[s][idx] && ref_cnt[s][idx] != 0) begin
            ref_cnt[s][idx]--;
            if (ref_cnt[s][idx] == 0) begin
              push_free(s, idx);
              e.freed = 1'b1;
            end
            e.byte_offset = offset_of(idx);
            e.status      = rpp_pkg::ST_OK;
          end
        end
        default: begin
        end
      endcase
      e.free_count = rpp_pkg::cnt_out_t'(free_top[s]);
      pending_results = {pending_results, e};
    endfunction

    // Compare a returned result with the oldest pending one
    function void check_result(rpp_pkg::res_t got);
      rpp_pkg::res_t e;
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: status %0d index %0d", got.status,
               got.granted_index);
        failures++;
        return;
      end
      e = pending_results.pop_front();
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        failures++;
      end
      if (got.granted_index !== e.granted_index) begin
        $error("granted_index expected %0d actual %0d", e.granted_index,
               got.granted_index);
        failures++;
      end
      if (got.byte_offset !== e.byte_offset) begin
        $error("byte_offset expected %0d actual %0d", e.byte_offset, got.byte_offset);
        failures++;
      end
      if (got.freed !== e.freed) begin
        $error("freed expected %0d actual %0d", e.freed, got.freed);
        failures++;
      end
      if (got.free_count !== e.free_count) begin
        $error("free_count expected %0d actual %0d", e.free_count, got.free_count);
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   quiet = 1'b0;

  pool_scoreboard sb;

  rpp_stream_if #(.payload_t(rpp_pkg::req_t)) req_if ();
  rpp_stream_if #(.payload_t(rpp_pkg::cfg_t)) cfg_if ();
  rpp_stream_if #(.payload_t(rpp_pkg::res_t)) res_if ();

  refcounted_packet_pool #(
    .SOURCES   (SOURCES),
    .PACKETS   (PACKETS),
    .MAX_FANOUT(MAX_FANOUT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Build a request, mostly well-formed against the current pool state
  function automatic rpp_pkg::req_t make_request();
    rpp_pkg::req_t     r;
    int unsigned       s;
    int unsigned       roll;
    rpp_pkg::pkt_idx_t cand[$];
    r.req_type     = rpp_pkg::REQ_ALLOC;
    r.source       = rpp_pkg::src_t'($urandom_range(0, SOURCES - 1));
    r.packet_index = rpp_pkg::pkt_idx_t'($urandom_range(0, 15));
    r.fanout       = rpp_pkg::fan_t'($urandom_range(0, 15));
    s    = r.source;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.req_type = 2'($urandom_range(0, 3));
    end else if (roll >= 40) begin
      r.req_type = (roll < 65) ? rpp_pkg::REQ_SUBMIT : rpp_pkg::REQ_RELEASE;
      for (int k = 0; k < PACKETS; k++) begin
        if (sb.in_use[s][k] &&
            ((sb.ref_cnt[s][k] == 0) == (r.req_type == rpp_pkg::REQ_SUBMIT)))
          cand = {cand, rpp_pkg::pkt_idx_t'(k)};
      end
      if (cand.size() != 0 && $urandom_range(0, 9) != 0)
        r.packet_index = cand[$urandom_range(0, cand.size() - 1)];
      // Keep most fanouts low so packets come back to the free lists
      if ($urandom_range(0, 3) != 0)
        r.fanout = rpp_pkg::fan_t'($urandom_range(0, 3));
    end
    return r;
  endfunction

  // Offer one request, with an optional idle burst first, and hold until taken
  task automatic send_request(input rpp_pkg::req_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(r);
  endtask

  task automatic write_register(input logic idx, input rpp_pkg::bytes_t v);
    rpp_pkg::cfg_t c;
    c.index = idx;
    c.value = v;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_register(c);
  endtask

  task automatic apply_settings(input rpp_pkg::bytes_t pool_val,
                                input rpp_pkg::bytes_t bytes_val);
    write_register(rpp_pkg::CFG_POOL_PACKETS, pool_val);
    write_register(rpp_pkg::CFG_PACKET_BYTES, bytes_val);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every pending result is back, then let the pipeline settle
  task automatic drain_results();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
  endtask

  // Check every returned result
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.data);
  end

  // Stall the result channel in random bursts
  initial begin
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // End the run when nothing moves on any channel for too long
  initial begin
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (res_if.valid && res_if.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("FAIL refcounted_packet_pool");
    $finish;
  end

  initial begin
    rpp_pkg::bytes_t pool_val;
    rpp_pkg::bytes_t bytes_val;
    sb = new();
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two-packet pool with upper bits set in the write, widest packet size
    apply_settings(16'h0022, 16'hFFFF);

    // Directed: exhaust a pool, then hit each bad submit and release case
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_ALLOC,   2'd0, 4'd15, 4'd15});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_ALLOC,   2'd0, 4'd0,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_ALLOC,   2'd0, 4'd0,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_SUBMIT,  2'd0, 4'd0,  4'd15});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_SUBMIT,  2'd0, 4'd0,  4'd3});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_RELEASE, 2'd0, 4'd1,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_SUBMIT,  2'd0, 4'd1,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_RELEASE, 2'd0, 4'd1,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_SUBMIT,  2'd0, 4'd15, 4'd15});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_RELEASE, 2'd0, 4'd15, 4'd0});
    send_request(rpp_pkg::req_t'{REQ_UNKNOWN,          2'd3, 4'd15, 4'd15});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_RELEASE, 2'd0, 4'd0,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_RELEASE, 2'd0, 4'd0,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_ALLOC,   2'd3, 4'd0,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_ALLOC,   2'd1, 4'd0,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_ALLOC,   2'd2, 4'd0,  4'd0});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_SUBMIT,  2'd3, 4'd0,  4'd1});
    send_request(rpp_pkg::req_t'{rpp_pkg::REQ_RELEASE, 2'd3, 4'd0,  4'd0});
    req_if.valid <= 1'b0;
    drain_results();

    // Random phases, each under its own pool and packet sizes
    for (int p = 0; p < NUM_PHASES; p++) begin
      bytes_val = rpp_pkg::bytes_t'($urandom_range(0, 65535));
      case (p)
        0: begin
          pool_val  = 16'h0000;
          bytes_val = 16'h0000;
        end
        1: begin
          pool_val  = rpp_pkg::bytes_t'(($urandom_range(0, 2047) << 5) | 31);
          bytes_val = 16'd64;
        end
        2: pool_val = 16'd3;
        3: begin
          pool_val  = rpp_pkg::bytes_t'(($urandom_range(0, 2047) << 5) |
                                        $urandom_range(17, 31));
          bytes_val = 16'd1;
        end
        4: pool_val = rpp_pkg::bytes_t'($urandom_range(2, 15));
        5: begin
          pool_val  = 16'd16;
          bytes_val = 16'hFFFF;
        end
        6: pool_val = rpp_pkg::bytes_t'($urandom_range(1, 16));
        default: pool_val = 16'd16;
      endcase
      apply_settings(pool_val, bytes_val);
      quiet = (p == NUM_PHASES - 1);
      repeat (PHASE_ITEMS) send_request(make_request());
      req_if.valid <= 1'b0;
      drain_results();
    end

    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("PASS refcounted_packet_pool");
    end else begin
      $display("FAIL refcounted_packet_pool");
    end
    $finish;
  end

endmodule
